### rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg: shared types and constants of the barrier payoff evaluator
// Register map, product kinds, reset values and the stage record that
// travels from the operand stage to the yield stage.
// ----------------------------------------------------------------------------
package bpe_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SCALED_W  = PROD_W - FRAC_BITS;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned INDEX_W   = 3;

  localparam logic [DATA_W-1:0] ONE_Q24 = 32'h0100_0000;
  localparam logic [DATA_W-1:0] SAT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_TWO_WAY = 2'd0,
    KIND_LONG    = 2'd1,
    KIND_SHORT   = 2'd2
  } kind_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_PRODUCT_KIND  = 3'd0,
    REG_UPPER_BARRIER = 3'd1,
    REG_LOWER_BARRIER = 3'd2,
    REG_BASE_RATE     = 3'd3,
    REG_FLOOR_RATE    = 3'd4,
    REG_REBATE        = 3'd5,
    REG_PARTICIPATION = 3'd6
  } reg_index_t;

  localparam logic [KIND_W-1:0] RST_PRODUCT_KIND  = 2'd0;
  localparam logic [DATA_W-1:0] RST_UPPER_BARRIER = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] RST_LOWER_BARRIER = 32'd0;
  localparam logic [DATA_W-1:0] RST_BASE_RATE     = 32'd310379;
  localparam logic [DATA_W-1:0] RST_FLOOR_RATE    = 32'd276824;
  localparam logic [DATA_W-1:0] RST_REBATE        = 32'd0;
  localparam logic [DATA_W-1:0] RST_PARTICIPATION = 32'd1681072;

  typedef struct packed {
    logic [KIND_W-1:0] product_kind;
    logic [DATA_W-1:0] upper_barrier;
    logic [DATA_W-1:0] lower_barrier;
    logic [DATA_W-1:0] base_rate;
    logic [DATA_W-1:0] two_way_floor_rate;
    logic [DATA_W-1:0] knocked_rebate;
    logic [DATA_W-1:0] participation;
  } cfg_t;

  // Operand stage to yield stage: one finished path, product already taken
  typedef struct packed {
    logic                valid;
    logic                knocked;
    logic [DATA_W-1:0]   base;
    logic [SCALED_W-1:0] scaled;
  } stage_t;

endpackage

### rtl/bpe_if.sv
// ----------------------------------------------------------------------------
// bpe_if: valid/ready channels of the barrier payoff evaluator
// Price channel toward the block and yield channel out of it.
// ----------------------------------------------------------------------------
interface bpe_price_if;
  logic                        valid;
  logic                        ready;
  logic [bpe_pkg::DATA_W-1:0]  price;
  logic                        last_step;

  modport source (output valid, price, last_step, input ready);
  modport sink   (input valid, price, last_step, output ready);
endinterface

interface bpe_yield_if;
  logic                        valid;
  logic                        ready;
  logic [bpe_pkg::DATA_W-1:0]  path_yield;
  logic                        was_knocked;

  modport source (output valid, path_yield, was_knocked, input ready);
  modport sink   (input valid, path_yield, was_knocked, output ready);
endinterface

### rtl/barrier_payoff_evaluator_unit.sv
// ----------------------------------------------------------------------------
// barrier_payoff_evaluator_unit: knock-out barrier option payoff per path
// Streams path prices and emits one yield per finished path.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries one price per transaction in time order; last_step marks
//   the final price of a path. result carries one transaction per finished
//   path: the saturated Q8.24 yield and whether the path was knocked out.
//   Unmarked prices produce no result and only update the knock-out flag.
//   Throughput: one price per cycle while result is not stalled, set by the
//   three-register pipeline (price register, product register, result
//   register) that moves as one.
//   When result is stalled the whole pipeline holds and sample.ready drops;
//   while the result register is empty sample.ready stays high.
//   Reset clears the pipeline, the knock-out flag and the configuration
//   registers to their defaults. Write configuration through cfg_write,
//   cfg_index and cfg_data only while no path is in flight; indexes past
//   the register list are ignored.
// ----------------------------------------------------------------------------
module barrier_payoff_evaluator_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [bpe_pkg::INDEX_W-1:0] cfg_index,
  input  logic [bpe_pkg::DATA_W-1:0]  cfg_data,
  bpe_price_if.sink                   sample,
  bpe_yield_if.source                 result
);

  bpe_pkg::cfg_t   cfg;
  bpe_pkg::stage_t mid;
  logic            advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.product_kind       <= bpe_pkg::RST_PRODUCT_KIND;
      cfg.upper_barrier      <= bpe_pkg::RST_UPPER_BARRIER;
      cfg.lower_barrier      <= bpe_pkg::RST_LOWER_BARRIER;
      cfg.base_rate          <= bpe_pkg::RST_BASE_RATE;
      cfg.two_way_floor_rate <= bpe_pkg::RST_FLOOR_RATE;
      cfg.knocked_rebate     <= bpe_pkg::RST_REBATE;
      cfg.participation      <= bpe_pkg::RST_PARTICIPATION;
    end else if (cfg_write) begin
      unique case (bpe_pkg::reg_index_t'(cfg_index))
        bpe_pkg::REG_PRODUCT_KIND:  cfg.product_kind <= cfg_data[bpe_pkg::KIND_W-1:0];
        bpe_pkg::REG_UPPER_BARRIER: cfg.upper_barrier      <= cfg_data;
        bpe_pkg::REG_LOWER_BARRIER: cfg.lower_barrier      <= cfg_data;
        bpe_pkg::REG_BASE_RATE:     cfg.base_rate          <= cfg_data;
        bpe_pkg::REG_FLOOR_RATE:    cfg.two_way_floor_rate <= cfg_data;
        bpe_pkg::REG_REBATE:        cfg.knocked_rebate     <= cfg_data;
        bpe_pkg::REG_PARTICIPATION: cfg.participation      <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the whole pipeline whenever the result register can take data
  assign advance      = !result.valid || result.ready;
  assign sample.ready = advance;

  bpe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .take      (sample.valid),
    .price     (sample.price),
    .last_step (sample.last_step),
    .cfg       (cfg),
    .stage     (mid)
  );

  bpe_back u_back (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .stage       (mid),
    .valid       (result.valid),
    .path_yield  (result.path_yield),
    .was_knocked (result.was_knocked)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> sample.ready)
    else $error("sample stalled while result register is empty");

  a_mid_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (mid.valid && advance) |=> result.valid)
    else $error("finished path lost between product and result register");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (!result.valid && !mid.valid))
    else $error("pipeline not empty after reset");

endmodule

### rtl/bpe_front.sv
// ----------------------------------------------------------------------------
// bpe_front: price register, knock-out flag and scaled-difference stage
// Compares each price with the barriers, keeps the sticky flag, picks the
// base yield and the difference, and registers participation * difference.
// ----------------------------------------------------------------------------
module bpe_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       take,
  input  logic [bpe_pkg::DATA_W-1:0] price,
  input  logic                       last_step,
  input  bpe_pkg::cfg_t              cfg,
  output bpe_pkg::stage_t            stage
);

  logic                         a_valid;
  logic [bpe_pkg::DATA_W-1:0]   a_price;
  logic                         a_last;
  logic                         knock_flag;

  logic                         above;
  logic                         below;
  logic                         hit;
  logic                         flag_now;
  logic                         fixed;
  logic [bpe_pkg::DATA_W-1:0]   base;
  logic [bpe_pkg::DATA_W-1:0]   diff;
  logic [bpe_pkg::PROD_W-1:0]   product;
  bpe_pkg::stage_t              stage_next;

  always_comb begin
    above = a_price > cfg.upper_barrier;
    below = a_price < cfg.lower_barrier;
    hit   = 1'b0;
    fixed = 1'b0;
    base  = cfg.base_rate;
    diff  = '0;

    unique case (bpe_pkg::kind_t'(cfg.product_kind))
      bpe_pkg::KIND_TWO_WAY: hit = above | below;
      bpe_pkg::KIND_LONG:    hit = above;
      default:               hit = below;
    endcase

    flag_now = knock_flag | hit;

    unique case (bpe_pkg::kind_t'(cfg.product_kind))
      bpe_pkg::KIND_TWO_WAY: begin
        if (flag_now) begin
          fixed = 1'b1;
          base  = cfg.base_rate;
        end else begin
          base = cfg.two_way_floor_rate;
          diff = (a_price >= bpe_pkg::ONE_Q24) ? a_price - bpe_pkg::ONE_Q24
                                               : bpe_pkg::ONE_Q24 - a_price;
        end
      end
      bpe_pkg::KIND_LONG: begin
        if (flag_now) begin
          fixed = 1'b1;
          base  = cfg.knocked_rebate;
        end else if (below) begin
          fixed = 1'b1;
        end else begin
          diff = a_price - cfg.lower_barrier;
        end
      end
      default: begin
        // unused kind code behaves as one-way short
        if (flag_now) begin
          fixed = 1'b1;
          base  = cfg.knocked_rebate;
        end else if (above) begin
          fixed = 1'b1;
        end else begin
          diff = cfg.upper_barrier - a_price;
        end
      end
    endcase

    product = {{bpe_pkg::DATA_W{1'b0}}, cfg.participation}
            * {{bpe_pkg::DATA_W{1'b0}}, diff};

    stage_next.valid   = a_valid & a_last;
    stage_next.knocked = flag_now;
    stage_next.base    = base;
    stage_next.scaled  = fixed ? '0 : product[bpe_pkg::PROD_W-1:bpe_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid     <= 1'b0;
      knock_flag  <= 1'b0;
      stage.valid <= 1'b0;
    end else if (advance) begin
      a_valid <= take;
      a_price <= price;
      a_last  <= last_step;
      // clear at the end of a path, otherwise accumulate
      if (a_valid) begin
        knock_flag <= a_last ? 1'b0 : flag_now;
      end
      stage <= stage_next;
    end
  end

endmodule

### rtl/bpe_back.sv
// ----------------------------------------------------------------------------
// bpe_back: saturating add and result register
// Adds the base yield to the scaled product and clamps at full scale.
// ----------------------------------------------------------------------------
module bpe_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  bpe_pkg::stage_t            stage,
  output logic                       valid,
  output logic [bpe_pkg::DATA_W-1:0] path_yield,
  output logic                       was_knocked
);

  localparam int unsigned SUM_W = bpe_pkg::SCALED_W + 1;

  logic [SUM_W-1:0]            sum;
  logic [bpe_pkg::DATA_W-1:0]  yield_next;

  always_comb begin
    sum = {{(SUM_W - bpe_pkg::DATA_W){1'b0}}, stage.base}
        + {1'b0, stage.scaled};
    yield_next = (|sum[SUM_W-1:bpe_pkg::DATA_W]) ? bpe_pkg::SAT_MAX
                                                 : sum[bpe_pkg::DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid       <= stage.valid;
      path_yield  <= yield_next;
      was_knocked <= stage.knocked;
    end
  end

endmodule
